### sv/udrs_pkg.sv
`timescale 1ns / 1ps

package udrs_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int ENTRY_BITS  = 32;
   localparam int IDX_BITS    = $clog2(STACK_DEPTH);
   localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
   localparam int KIND_BITS   = 3;

   typedef logic [ENTRY_BITS-1:0] entry_type;
   typedef logic [CNT_BITS-1:0]   count_type;
   typedef logic [IDX_BITS-1:0]   index_type;

   typedef enum logic [KIND_BITS-1:0] {
      REQ_PUSH = 3'd0,
      REQ_POP  = 3'd1,
      REQ_UNDO = 3'd2,
      REQ_REDO = 3'd3,
      REQ_PEEK = 3'd4
   } req_kind_type;

endpackage

### sv/undo_redo_stack.sv
// An accepted word is held in the input register; its result is then written to the result register.
// Throughput: one request word per cycle; the input register and the result register
// pass each other unless the result side stalls.
// Reset (synchronous, active high) empties both stacks and drops any word in flight;
// stack entries themselves are not cleared.
`timescale 1ns / 1ps

module undo_redo_stack (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [udrs_pkg::KIND_BITS-1:0]     req_type,
   input  logic [udrs_pkg::ENTRY_BITS-1:0]    req_entry_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_status_error,
   output logic                               rsp_top_valid,
   output logic [udrs_pkg::ENTRY_BITS-1:0]    rsp_top_entry,
   output logic [udrs_pkg::CNT_BITS-1:0]      rsp_main_count,
   output logic [udrs_pkg::CNT_BITS-1:0]      rsp_redo_count
);

   import udrs_pkg::*;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic [KIND_BITS-1:0]   s1_type_ff;
   entry_type              s1_data_ff;

   entry_type              main_store_ff [STACK_DEPTH];
   entry_type              redo_store_ff [STACK_DEPTH];
   entry_type              main_top_ff, main_top_in;
   count_type              main_fill_ff, main_fill_in;
   count_type              redo_fill_ff, redo_fill_in;

   logic                   status_error_ff, top_valid_ff;
   entry_type              top_entry_ff;

   logic                   advance, take, commit, refused;
   logic                   main_empty, main_full, redo_empty, redo_full;
   logic                   main_wr, redo_wr;
   entry_type              main_wr_data, below_entry, redo_top_entry;
   index_type              below_idx, redo_top_idx;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign commit    = s1_valid_ff && advance;

   assign s1_valid_in  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   assign main_empty = (main_fill_ff == '0);
   assign main_full  = (main_fill_ff == CNT_BITS'(STACK_DEPTH));
   assign redo_empty = (redo_fill_ff == '0);
   assign redo_full  = (redo_fill_ff == CNT_BITS'(STACK_DEPTH));

   assign below_idx      = main_fill_ff[IDX_BITS-1:0] - IDX_BITS'(2);
   assign redo_top_idx   = redo_fill_ff[IDX_BITS-1:0] - IDX_BITS'(1);
   assign below_entry    = main_store_ff[below_idx];
   assign redo_top_entry = redo_store_ff[redo_top_idx];

   always_comb begin
      main_fill_in = main_fill_ff;
      redo_fill_in = redo_fill_ff;
      main_top_in  = main_top_ff;
      main_wr      = 1'b0;
      main_wr_data = s1_data_ff;
      redo_wr      = 1'b0;
      refused      = 1'b0;
      case (req_kind_type'(s1_type_ff))
         REQ_PUSH: begin
            if (!main_full) begin
               main_wr      = 1'b1;
               main_wr_data = s1_data_ff;
               main_top_in  = s1_data_ff;
               main_fill_in = main_fill_ff + CNT_BITS'(1);
               redo_fill_in = '0;
            end else begin
               refused = 1'b1;
            end
         end
         REQ_POP: begin
            if (!main_empty) begin
               main_fill_in = main_fill_ff - CNT_BITS'(1);
               main_top_in  = below_entry;
            end else begin
               refused = 1'b1;
            end
         end
         REQ_UNDO: begin
            if (!main_empty && !redo_full) begin
               redo_wr      = 1'b1;
               redo_fill_in = redo_fill_ff + CNT_BITS'(1);
               main_fill_in = main_fill_ff - CNT_BITS'(1);
               main_top_in  = below_entry;
            end else begin
               refused = 1'b1;
            end
         end
         REQ_REDO: begin
            if (!redo_empty && !main_full) begin
               main_wr      = 1'b1;
               main_wr_data = redo_top_entry;
               main_top_in  = redo_top_entry;
               main_fill_in = main_fill_ff + CNT_BITS'(1);
               redo_fill_in = redo_fill_ff - CNT_BITS'(1);
            end else begin
               refused = 1'b1;
            end
         end
         REQ_PEEK: begin
            refused = 1'b0;
         end
         default: begin
            refused = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         main_fill_ff <= '0;
         redo_fill_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (commit) begin
            main_fill_ff <= main_fill_in;
            redo_fill_ff <= redo_fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_type_ff <= req_type;
         s1_data_ff <= req_entry_data;
      end
      if (commit) begin
         main_top_ff     <= main_top_in;
         status_error_ff <= refused;
         top_valid_ff    <= (main_fill_in != '0);
         top_entry_ff    <= (main_fill_in != '0) ? main_top_in : '0;
         if (main_wr) begin
            main_store_ff[main_fill_ff[IDX_BITS-1:0]] <= main_wr_data;
         end
         if (redo_wr) begin
            redo_store_ff[redo_fill_ff[IDX_BITS-1:0]] <= main_top_ff;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status_error = status_error_ff;
   assign rsp_top_valid    = top_valid_ff;
   assign rsp_top_entry    = top_entry_ff;
   assign rsp_main_count   = main_fill_ff;
   assign rsp_redo_count   = redo_fill_ff;

endmodule

### sv/udrs_check.sv
`timescale 1ns / 1ps

module udrs_check (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_status_error,
   input logic                               rsp_top_valid,
   input logic [udrs_pkg::ENTRY_BITS-1:0]    rsp_top_entry,
   input logic [udrs_pkg::CNT_BITS-1:0]      rsp_main_count,
   input logic [udrs_pkg::CNT_BITS-1:0]      rsp_redo_count
);

   import udrs_pkg::*;

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_top_entry)
         && $stable(rsp_main_count) && $stable(rsp_redo_count)
         && $stable(rsp_status_error))
      else $error("stalled result word changed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_main_count <= CNT_BITS'(STACK_DEPTH)
         && rsp_redo_count <= CNT_BITS'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_top_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_top_valid == (rsp_main_count != '0))
      else $error("top valid disagrees with main count");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_top_valid |-> rsp_top_entry == '0)
      else $error("empty stack shows nonzero top");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && rsp_main_count == '0 && rsp_redo_count == '0)
      else $error("result or counts left after reset");

endmodule

bind undo_redo_stack udrs_check u_udrs_check (.*);
